[rtl/core/scep_pkg.sv]
// Shared types, constants and the helper function of the superscript exponent parser.
`default_nettype none

package scep_pkg;

    // Span length limit
    localparam int MAX_SPAN   = 4095;
    localparam int SPAN_LIMIT = (MAX_SPAN < 4095) ? MAX_SPAN : 4095;
    localparam int LEN_W      = 12;

    // Event queue between decoder and term parser
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Code points of interest
    localparam logic [20:0] CP_SUP0  = 21'h02070;
    localparam logic [20:0] CP_SUP1  = 21'h000B9;
    localparam logic [20:0] CP_SUP2  = 21'h000B2;
    localparam logic [20:0] CP_SUP3  = 21'h000B3;
    localparam logic [20:0] CP_SUP4  = 21'h02074;
    localparam logic [20:0] CP_SUP9  = 21'h02079;
    localparam logic [20:0] CP_PLUS  = 21'h0207A;
    localparam logic [20:0] CP_MINUS = 21'h0207B;
    localparam logic [20:0] CP_I     = 21'h02071;

    // What one decoder beat means to the parser
    typedef enum logic [1:0] {
        EV_NONE,
        EV_CODE,
        EV_FAIL,
        EV_LIMIT
    } ev_kind_t;

    // Class of a complete code point
    typedef enum logic [2:0] {
        CL_OTHER,
        CL_DIGIT,
        CL_I,
        CL_PLUS,
        CL_MINUS
    } cp_class_t;

    // Term parser phase
    typedef enum logic [1:0] {
        PH_START,
        PH_SIGNED,
        PH_AFTER_I,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        ev_kind_t          kind;
        cp_class_t         cls;
        logic [3:0]        dval;
        logic [LEN_W-1:0]  pos;
        logic              last;
        logic              trunc;
    } ev_t;

    // Span outcome, with the pending term not yet added
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [31:0]       re;
        logic [31:0]       im;
        logic              ovf;
        logic              add_en;
        logic              add_imag;
        logic              neg;
        logic [31:0]       mag;
    } fin_t;

    // Signed 32-bit sum plus or minus an unsigned magnitude; MSB flags overflow
    function automatic logic [32:0] add_signed(
        input logic [31:0] acc,
        input logic [31:0] mag,
        input logic        neg
    );
        logic [33:0] a;
        logic [33:0] m;
        logic [33:0] e;
        logic        o;
        a = {{2{acc[31]}}, acc};
        m = {2'b00, mag};
        e = neg ? (a - m) : (a + m);
        o = (e[33:31] != 3'b000) && (e[33:31] != 3'b111);
        return {o, e[31:0]};
    endfunction

endpackage

`default_nettype wire

[rtl/core/scep_front.sv]
// Front end: accepts text bytes, decodes UTF-8 and classifies code points.
`default_nettype none

module scep_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [7:0]                 byte_req,
    input  wire logic                       last,
    input  wire logic                       q_full,
    output logic                            q_push,
    output scep_pkg::ev_t                   q_ev
);

    logic [20:0]                cp_reg;
    logic [20:0]                cp_next;
    logic [1:0]                 pend_reg;
    logic [1:0]                 pend_next;
    logic [scep_pkg::LEN_W-1:0] cnt_reg;
    logic [scep_pkg::LEN_W-1:0] cnt_next;

    localparam logic [scep_pkg::LEN_W-1:0] LIMIT = scep_pkg::LEN_W'(scep_pkg::SPAN_LIMIT);

    // Map a code point onto its term role
    function automatic scep_pkg::cp_class_t classify(input logic [20:0] c);
        scep_pkg::cp_class_t r;
        r = scep_pkg::CL_OTHER;
        if (c == scep_pkg::CP_I)
            r = scep_pkg::CL_I;
        else if (c == scep_pkg::CP_PLUS)
            r = scep_pkg::CL_PLUS;
        else if (c == scep_pkg::CP_MINUS)
            r = scep_pkg::CL_MINUS;
        else if (c inside {scep_pkg::CP_SUP0, scep_pkg::CP_SUP1, scep_pkg::CP_SUP2,
                           scep_pkg::CP_SUP3, [scep_pkg::CP_SUP4:scep_pkg::CP_SUP9]})
            r = scep_pkg::CL_DIGIT;
        return r;
    endfunction

    function automatic logic [3:0] digit_of(input logic [20:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c == scep_pkg::CP_SUP1)
            d = 4'd1;
        else if (c == scep_pkg::CP_SUP2)
            d = 4'd2;
        else if (c == scep_pkg::CP_SUP3)
            d = 4'd3;
        else if (c inside {[scep_pkg::CP_SUP4:scep_pkg::CP_SUP9]})
            d = 4'd4 + c[3:0] - scep_pkg::CP_SUP4[3:0];
        return d;
    endfunction

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Decode one byte into an event
    always_comb
    begin
        logic [20:0] v;
        logic        bad;
        v         = ((cp_reg << 6) | {15'd0, byte_req[5:0]});
        bad       = 1'b0;
        cp_next   = cp_reg;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        q_ev       = '0;
        q_ev.kind  = scep_pkg::EV_NONE;
        q_ev.cls   = scep_pkg::CL_OTHER;
        q_ev.pos   = cnt_reg + 1'b1;
        q_ev.last  = last;
        if (cnt_reg == LIMIT)
        begin
            q_ev.kind  = scep_pkg::EV_LIMIT;
            q_ev.trunc = (pend_reg != 2'd0);
        end
        else
        begin
            cnt_next = cnt_reg + 1'b1;
            if (pend_reg == 2'd0)
            begin
                if (byte_req < 8'h80)
                begin
                    q_ev.kind = scep_pkg::EV_CODE;
                    q_ev.cls  = classify({13'd0, byte_req});
                    q_ev.dval = digit_of({13'd0, byte_req});
                end
                else if (byte_req inside {[8'hC2:8'hDF]})
                begin
                    cp_next   = {16'd0, byte_req[4:0]};
                    pend_next = 2'd1;
                end
                else if (byte_req inside {[8'hE0:8'hEF]})
                begin
                    cp_next   = {17'd0, byte_req[3:0]};
                    pend_next = 2'd2;
                end
                else if (byte_req inside {[8'hF0:8'hF7]})
                begin
                    cp_next   = {18'd0, byte_req[2:0]};
                    pend_next = 2'd3;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            else
            begin
                if (byte_req[7:6] != 2'b10)
                    bad = 1'b1;
                else if (pend_reg == 2'd3)
                    bad = (v < 21'h10) || (v > 21'h10F);
                else if (pend_reg == 2'd2 && cp_reg <= 21'h0F)
                    bad = (v < 21'h20) || (v >= 21'h360 && v <= 21'h37F);
                if (!bad)
                begin
                    cp_next   = v;
                    pend_next = pend_reg - 2'd1;
                    if (pend_reg == 2'd1)
                    begin
                        q_ev.kind = scep_pkg::EV_CODE;
                        q_ev.cls  = classify(v);
                        q_ev.dval = digit_of(v);
                    end
                end
            end
            if (bad)
            begin
                q_ev.kind = scep_pkg::EV_FAIL;
                pend_next = 2'd0;
            end
            q_ev.trunc = (pend_next != 2'd0);
        end
        // Span end: decoder starts clean
        if (last)
        begin
            pend_next = 2'd0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg   <= '0;
            pend_reg <= 2'd0;
            cnt_reg  <= '0;
        end
        else if (q_push)
        begin
            cp_reg   <= cp_next;
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

    // The byte counter never runs past the span limit and restarts after a final beat
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LIMIT)
        else $error("byte counter past span limit");
    a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && last |=> cnt_reg == '0 && pend_reg == 2'd0)
        else $error("decoder not cleared after final beat");

endmodule

`default_nettype wire

[rtl/core/scep_queue.sv]
// Short event queue between the decoder and the term parser.
`default_nettype none

module scep_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire scep_pkg::ev_t  push_ev,
    output logic                full,
    input  wire logic           pop,
    output logic                q_valid,
    output scep_pkg::ev_t       q_ev
);

    scep_pkg::ev_t                 mem [scep_pkg::QDEPTH];
    logic [scep_pkg::QPTR_W-1:0]   wr_reg;
    logic [scep_pkg::QPTR_W-1:0]   wr_next;
    logic [scep_pkg::QPTR_W-1:0]   rd_reg;
    logic [scep_pkg::QPTR_W-1:0]   rd_next;
    logic [scep_pkg::QCNT_W-1:0]   cnt_reg;
    logic [scep_pkg::QCNT_W-1:0]   cnt_next;

    localparam logic [scep_pkg::QCNT_W-1:0] DEPTH = scep_pkg::QCNT_W'(scep_pkg::QDEPTH);
    localparam logic [scep_pkg::QPTR_W-1:0] LAST_SLOT =
        scep_pkg::QPTR_W'(scep_pkg::QDEPTH - 1);

    assign full    = (cnt_reg == DEPTH);
    assign q_valid = (cnt_reg != '0);
    assign q_ev    = mem[rd_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == LAST_SLOT) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_ev;
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH && (cnt_reg == '0 || cnt_reg == DEPTH || wr_reg != rd_reg))
        else $error("queue fill count out of step with pointers");

endmodule

`default_nettype wire

[rtl/core/scep_back.sv]
// Term parser: sums superscript terms from classified code points.
`default_nettype none

module scep_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire scep_pkg::ev_t  q_ev,
    output logic                q_pop,
    output logic                rec_valid,
    output scep_pkg::fin_t      rec,
    input  wire logic           rec_ready
);

    scep_pkg::phase_t               phase_reg;
    scep_pkg::phase_t               phase_next;
    logic                           first_reg;
    logic                           first_next;
    logic                           neg_reg;
    logic                           neg_next;
    logic                           sign_reg;
    logic                           sign_next;
    logic                           imf_reg;
    logic                           imf_next;
    logic                           done_reg;
    logic                           done_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic [31:0]                    num_reg;
    logic [31:0]                    num_next;
    logic [31:0]                    re_reg;
    logic [31:0]                    re_next;
    logic [31:0]                    im_reg;
    logic [31:0]                    im_next;
    logic [scep_pkg::LEN_W-1:0]     len_reg;
    logic [scep_pkg::LEN_W-1:0]     len_next;

    // Values after this beat, before the end-of-span clear
    scep_pkg::phase_t               e_phase;
    logic                           e_first;
    logic                           e_neg;
    logic                           e_sign;
    logic                           e_imf;
    logic                           e_done;
    logic                           e_ovf;
    logic [31:0]                    e_num;
    logic [31:0]                    e_re;
    logic [31:0]                    e_im;
    logic [scep_pkg::LEN_W-1:0]     e_len;
    logic                           e_add;

    logic [35:0]                    mul10;
    logic [32:0]                    term_sum;
    logic                           term_to_im;

    // Decimal digit accumulate: n * 10 + d
    assign mul10 = ({4'd0, num_reg} << 3) + ({4'd0, num_reg} << 1) + {32'd0, q_ev.dval};

    // Adds the term in progress to its sum
    assign term_to_im = imf_reg || (phase_reg == scep_pkg::PH_AFTER_I) ||
                        (phase_reg == scep_pkg::PH_DIGITS && q_ev.cls == scep_pkg::CL_I);
    assign term_sum = scep_pkg::add_signed(term_to_im ? im_reg : re_reg,
                          (phase_reg == scep_pkg::PH_DIGITS) ? num_reg : 32'd1, neg_reg);

    assign q_pop     = q_valid && (!q_ev.last || rec_ready);
    assign rec_valid = q_pop && q_ev.last;

    // Next state of the term parser
    always_comb
    begin
        logic do_start;
        logic do_body;
        logic allowed;
        logic dig_cls;
        logic eos;
        e_phase  = phase_reg;
        e_first  = first_reg;
        e_neg    = neg_reg;
        e_sign   = sign_reg;
        e_imf    = imf_reg;
        e_done   = done_reg;
        e_ovf    = ovf_reg;
        e_num    = num_reg;
        e_re     = re_reg;
        e_im     = im_reg;
        e_len    = len_reg;
        e_add    = 1'b0;
        do_start = 1'b0;
        do_body  = 1'b0;
        allowed  = 1'b0;
        eos      = 1'b0;
        dig_cls  = (q_ev.cls == scep_pkg::CL_DIGIT);
        if (q_pop && !done_reg)
        begin
            case (q_ev.kind)
                scep_pkg::EV_FAIL:
                begin
                    e_len  = '0;
                    e_re   = '0;
                    e_im   = '0;
                    e_done = 1'b1;
                end
                scep_pkg::EV_LIMIT:
                begin
                    e_ovf = 1'b1;
                    eos   = 1'b1;
                end
                scep_pkg::EV_CODE:
                begin
                    case (phase_reg)
                        scep_pkg::PH_START:
                            do_start = 1'b1;
                        scep_pkg::PH_SIGNED:
                            do_body = 1'b1;
                        scep_pkg::PH_AFTER_I:
                        begin
                            if (dig_cls)
                            begin
                                e_num   = {28'd0, q_ev.dval};
                                e_len   = q_ev.pos;
                                e_phase = scep_pkg::PH_DIGITS;
                            end
                            else if (q_ev.cls == scep_pkg::CL_I)
                            begin
                                e_len  = '0;
                                e_re   = '0;
                                e_im   = '0;
                                e_done = 1'b1;
                            end
                            else
                            begin
                                do_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (dig_cls)
                            begin
                                e_num = mul10[31:0];
                                if (mul10[35:31] != 5'd0)
                                    e_ovf = 1'b1;
                                e_len = q_ev.pos;
                            end
                            else if (q_ev.cls == scep_pkg::CL_I)
                            begin
                                if (imf_reg)
                                begin
                                    e_len  = '0;
                                    e_re   = '0;
                                    e_im   = '0;
                                    e_done = 1'b1;
                                end
                                else
                                begin
                                    e_len = q_ev.pos;
                                end
                            end
                            else
                            begin
                                do_start = 1'b1;
                            end
                        end
                    endcase
                    // Close the running term: after an i, or before a new term
                    if (phase_reg == scep_pkg::PH_DIGITS || phase_reg == scep_pkg::PH_AFTER_I)
                    begin
                        if (do_start || (phase_reg == scep_pkg::PH_DIGITS &&
                            q_ev.cls == scep_pkg::CL_I && !imf_reg))
                        begin
                            if (term_to_im)
                                e_im = term_sum[31:0];
                            else
                                e_re = term_sum[31:0];
                            if (term_sum[32])
                                e_ovf = 1'b1;
                            e_phase = scep_pkg::PH_START;
                            e_first = 1'b0;
                            e_neg   = 1'b0;
                            e_sign  = 1'b0;
                            e_imf   = 1'b0;
                            e_num   = '0;
                        end
                    end
                    // Optional sign
                    if (do_start)
                    begin
                        if (q_ev.cls == scep_pkg::CL_PLUS || q_ev.cls == scep_pkg::CL_MINUS)
                        begin
                            e_sign  = 1'b1;
                            e_neg   = e_neg || (q_ev.cls == scep_pkg::CL_MINUS);
                            e_phase = scep_pkg::PH_SIGNED;
                        end
                        else
                        begin
                            do_body = 1'b1;
                        end
                    end
                    // Term body start
                    if (do_body)
                    begin
                        allowed = e_sign || e_first;
                        if (q_ev.cls == scep_pkg::CL_I || dig_cls)
                        begin
                            if (!allowed)
                            begin
                                e_len  = '0;
                                e_re   = '0;
                                e_im   = '0;
                                e_done = 1'b1;
                            end
                            else if (dig_cls)
                            begin
                                e_num   = {28'd0, q_ev.dval};
                                e_len   = q_ev.pos;
                                e_phase = scep_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                e_imf   = 1'b1;
                                e_len   = q_ev.pos;
                                e_phase = scep_pkg::PH_AFTER_I;
                            end
                        end
                        else if (e_sign)
                        begin
                            e_len  = '0;
                            e_re   = '0;
                            e_im   = '0;
                            e_done = 1'b1;
                        end
                        else
                        begin
                            e_done = 1'b1;
                        end
                    end
                    eos = q_ev.last && !e_done;
                end
                default:
                    eos = q_ev.last;
            endcase
            // End of span: truncated code point or dangling sign fails
            if (eos)
            begin
                if (q_ev.trunc || e_phase == scep_pkg::PH_SIGNED)
                begin
                    e_len = '0;
                    e_re  = '0;
                    e_im  = '0;
                end
                else
                begin
                    e_add = (e_phase == scep_pkg::PH_DIGITS) ||
                            (e_phase == scep_pkg::PH_AFTER_I);
                end
                e_done = 1'b1;
            end
        end
    end

    // Register updates and result record
    always_comb
    begin
        rec          = '0;
        rec.len      = e_len;
        rec.re       = e_re;
        rec.im       = e_im;
        rec.ovf      = e_ovf;
        rec.add_en   = e_add;
        rec.add_imag = e_imf || (e_phase == scep_pkg::PH_AFTER_I);
        rec.neg      = e_neg;
        rec.mag      = (e_phase == scep_pkg::PH_DIGITS) ? e_num : 32'd1;
        phase_next = e_phase;
        first_next = e_first;
        neg_next   = e_neg;
        sign_next  = e_sign;
        imf_next   = e_imf;
        done_next  = e_done;
        ovf_next   = e_ovf;
        num_next   = e_num;
        re_next    = e_re;
        im_next    = e_im;
        len_next   = e_len;
        if (rec_valid)
        begin
            phase_next = scep_pkg::PH_START;
            first_next = 1'b1;
            neg_next   = 1'b0;
            sign_next  = 1'b0;
            imf_next   = 1'b0;
            done_next  = 1'b0;
            ovf_next   = 1'b0;
            num_next   = '0;
            re_next    = '0;
            im_next    = '0;
            len_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= scep_pkg::PH_START;
            first_reg <= 1'b1;
            neg_reg   <= 1'b0;
            sign_reg  <= 1'b0;
            imf_reg   <= 1'b0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            num_reg   <= '0;
            re_reg    <= '0;
            im_reg    <= '0;
            len_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            neg_reg   <= neg_next;
            sign_reg  <= sign_next;
            imf_reg   <= imf_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
            num_reg   <= num_next;
            re_reg    <= re_next;
            im_reg    <= im_next;
            len_reg   <= len_next;
        end
    end

    // Once decided, later beats of the span leave the sums alone
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && done_reg && !q_ev.last |=> $stable(re_reg) && $stable(im_reg) && done_reg)
        else $error("sums changed after span outcome was fixed");
    // No accepted bytes means no sums and no pending term
    a_empty_rec: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec.len == '0 |-> rec.re == '0 && rec.im == '0 && !rec.add_en)
        else $error("zero-length result carries a sum");

endmodule

`default_nettype wire

[rtl/core/scep_out.sv]
// Result stage: adds the last pending term, then holds the result for the consumer.
`default_nettype none

module scep_out (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rec_valid,
    input  wire scep_pkg::fin_t             rec,
    output logic                            rec_ready,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [scep_pkg::LEN_W-1:0]      length,
    output logic signed [31:0]              real_part,
    output logic signed [31:0]              imag_part,
    output logic                            overflow
);

    logic                           fin_valid_reg;
    scep_pkg::fin_t                 fin_reg;
    logic                           out_valid_reg;
    logic [scep_pkg::LEN_W-1:0]     len_reg;
    logic [31:0]                    re_reg;
    logic [31:0]                    re_next;
    logic [31:0]                    im_reg;
    logic [31:0]                    im_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic                           out_free;
    logic                           fin_free;
    logic [32:0]                    sum;

    assign out_free  = !out_valid_reg || !out_stall;
    assign fin_free  = !fin_valid_reg || out_free;
    assign rec_ready = fin_free;

    // Final term add
    assign sum = scep_pkg::add_signed(fin_reg.add_imag ? fin_reg.im : fin_reg.re,
                                      fin_reg.mag, fin_reg.neg);

    always_comb
    begin
        re_next  = fin_reg.re;
        im_next  = fin_reg.im;
        ovf_next = fin_reg.ovf;
        if (fin_reg.add_en)
        begin
            if (fin_reg.add_imag)
                im_next = sum[31:0];
            else
                re_next = sum[31:0];
            ovf_next = fin_reg.ovf || sum[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_free)
                fin_valid_reg <= rec_valid;
            if (out_free)
                out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_free && rec_valid)
            fin_reg <= rec;
        if (out_free && fin_valid_reg)
        begin
            len_reg <= fin_reg.len;
            re_reg  <= re_next;
            im_reg  <= im_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign length    = len_reg;
    assign real_part = re_reg;
    assign imag_part = im_reg;
    assign overflow  = ovf_reg;

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && out_free |=> out_valid_reg)
        else $error("staged result lost on its way to the output register");

endmodule

`default_nettype wire

[rtl/core/superscript_complex_exponent_parser_top.sv]
// Top level of the superscript complex exponent parser.
// Takes one UTF-8 byte per beat and gives one result beat on each byte marked last: the
// byte length of the leading run of superscript terms, its real and imaginary sums, and
// an overflow flag. Bytes are accepted at one per cycle as long as the four-entry event
// queue between the UTF-8 decoder and the term parser has room; the parser drains one
// event per cycle unless the final-add stage cannot take a result, and a result passes
// through the final-add stage before it sits in the output register. Spans longer than
// 4095 bytes flag overflow and are judged at that point.
`default_nettype none

module superscript_complex_exponent_parser_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [7:0]                 byte_req,
    input  wire logic                       last,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [scep_pkg::LEN_W-1:0]      length,
    output logic signed [31:0]              real_part,
    output logic signed [31:0]              imag_part,
    output logic                            overflow
);

    logic               q_full;
    logic               q_push;
    scep_pkg::ev_t      push_ev;
    logic               q_pop;
    logic               q_valid;
    scep_pkg::ev_t      q_ev;
    logic               rec_valid;
    logic               rec_ready;
    scep_pkg::fin_t     rec;

    scep_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .byte_req (byte_req),
        .last     (last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ev     (push_ev)
    );

    scep_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_ev (push_ev),
        .full    (q_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .q_ev    (q_ev)
    );

    scep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ev      (q_ev),
        .q_pop     (q_pop),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready)
    );

    scep_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .length    (length),
        .real_part (real_part),
        .imag_part (imag_part),
        .overflow  (overflow)
    );

endmodule

`default_nettype wire

[test/tb_superscript_complex_exponent_parser_top.sv]
// Self-checking testbench for the superscript complex exponent parser top level.
module tb_superscript_complex_exponent_parser_top;

    import scep_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // Expected outcome of one span
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic              ovf;
    } span_result_t;

    // Exponent predictor plus the queue of outcomes still owed by the block
    class exponent_scoreboard;
        bit [20:0]        cp_acc;
        int unsigned      cont_left;
        int unsigned      byte_pos;
        bit [LEN_W-1:0]   taken_len;
        phase_t           phase;
        bit               first_term;
        bit               term_neg;
        bit               term_has_sign;
        bit               term_imag;
        bit [31:0]        term_value;
        bit [31:0]        re_sum;
        bit [31:0]        im_sum;
        bit               ovf_seen;
        bit               outcome_fixed;
        span_result_t     expected_q[$];
        int unsigned      errors;
        int unsigned      results;
        int unsigned      spans;
        int unsigned      rejected;
        int unsigned      ovf_spans;
        int unsigned      imag_spans;

        function new();
            clear_span();
        endfunction

        function void clear_span();
            cp_acc        = '0;
            cont_left     = 0;
            byte_pos      = 0;
            taken_len     = '0;
            phase         = PH_START;
            first_term    = 1'b1;
            term_neg      = 1'b0;
            term_has_sign = 1'b0;
            term_imag     = 1'b0;
            term_value    = '0;
            re_sum        = '0;
            im_sum        = '0;
            ovf_seen      = 1'b0;
            outcome_fixed = 1'b0;
        endfunction

        function int digit_of(bit [20:0] c);
            if (c == CP_SUP0) return 0;
            if (c == CP_SUP1) return 1;
            if (c == CP_SUP2) return 2;
            if (c == CP_SUP3) return 3;
            if (c >= CP_SUP4 && c <= CP_SUP9) return 4 + int'(c - CP_SUP4);
            return -1;
        endfunction

        // Signed 32-bit accumulate with wrap; flags leaving the range
        function bit [31:0] add_with_sign(bit [31:0] acc, bit [31:0] mag, bit sub);
            longint a;
            longint m;
            longint e;
            a = longint'($signed(acc));
            m = longint'(mag);
            e = sub ? a - m : a + m;
            if (e < -(longint'(1) << 31) || e >= (longint'(1) << 31)) ovf_seen = 1'b1;
            return e[31:0];
        endfunction

        function void reject();
            taken_len     = '0;
            re_sum        = '0;
            im_sum        = '0;
            outcome_fixed = 1'b1;
        endfunction

        function void close_term();
            if (phase == PH_DIGITS) begin
                if (term_imag) im_sum = add_with_sign(im_sum, term_value, term_neg);
                else           re_sum = add_with_sign(re_sum, term_value, term_neg);
            end
            else if (phase == PH_AFTER_I) begin
                im_sum = add_with_sign(im_sum, 32'd1, term_neg);
            end
            phase         = PH_START;
            first_term    = 1'b0;
            term_neg      = 1'b0;
            term_has_sign = 1'b0;
            term_imag     = 1'b0;
            term_value    = '0;
        endfunction

        // First code point of a term body, after an optional sign
        function void body_start(bit [20:0] c);
            bit allowed;
            int d;
            allowed = term_has_sign || first_term;
            d = digit_of(c);
            if (c == CP_I) begin
                if (!allowed) begin
                    reject();
                    return;
                end
                term_imag = 1'b1;
                taken_len = byte_pos[LEN_W-1:0];
                phase     = PH_AFTER_I;
            end
            else if (d >= 0) begin
                if (!allowed) begin
                    reject();
                    return;
                end
                term_value = 32'(d);
                taken_len  = byte_pos[LEN_W-1:0];
                phase      = PH_DIGITS;
            end
            else if (term_has_sign) reject();
            else outcome_fixed = 1'b1;
        endfunction

        function void at_start(bit [20:0] c);
            if (c == CP_PLUS || c == CP_MINUS) begin
                term_has_sign = 1'b1;
                if (c == CP_MINUS) term_neg = 1'b1;
                phase = PH_SIGNED;
            end
            else body_start(c);
        endfunction

        function void take_cp(bit [20:0] c);
            int d;
            longint n;
            d = digit_of(c);
            case (phase)
                PH_START:  at_start(c);
                PH_SIGNED: body_start(c);
                PH_AFTER_I:
                begin
                    if (d >= 0) begin
                        term_value = 32'(d);
                        taken_len  = byte_pos[LEN_W-1:0];
                        phase      = PH_DIGITS;
                    end
                    else if (c == CP_I) reject();
                    else begin
                        close_term();
                        at_start(c);
                    end
                end
                default:
                begin
                    if (d >= 0) begin
                        n = longint'(term_value) * 10 + d;
                        if (n > 64'h7FFF_FFFF) ovf_seen = 1'b1;
                        term_value = n[31:0];
                        taken_len  = byte_pos[LEN_W-1:0];
                    end
                    else if (c == CP_I) begin
                        if (term_imag) reject();
                        else begin
                            term_imag = 1'b1;
                            taken_len = byte_pos[LEN_W-1:0];
                            close_term();
                        end
                    end
                    else begin
                        close_term();
                        at_start(c);
                    end
                end
            endcase
        endfunction

        function void span_end();
            if (cont_left != 0 || phase == PH_SIGNED) begin
                reject();
                return;
            end
            if (phase != PH_START) close_term();
            outcome_fixed = 1'b1;
        endfunction

        // UTF-8 decode: lead byte, then continuations with overlong/surrogate/range checks
        function void take_byte(bit [7:0] b);
            bit [20:0] v;
            byte_pos++;
            if (cont_left == 0) begin
                if (b < 8'h80) take_cp({13'd0, b});
                else if (b >= 8'hC2 && b <= 8'hDF) begin
                    cp_acc    = {16'd0, b[4:0]};
                    cont_left = 1;
                end
                else if (b >= 8'hE0 && b <= 8'hEF) begin
                    cp_acc    = {17'd0, b[3:0]};
                    cont_left = 2;
                end
                else if (b >= 8'hF0 && b <= 8'hF7) begin
                    cp_acc    = {18'd0, b[2:0]};
                    cont_left = 3;
                end
                else reject();
                return;
            end
            if (b[7:6] != 2'b10) begin
                reject();
                return;
            end
            v = {cp_acc[14:0], b[5:0]};
            if (cont_left == 3 && (v < 21'h10 || v > 21'h10F)) begin
                reject();
                return;
            end
            if (cont_left == 2 && cp_acc <= 21'h0F &&
                (v < 21'h20 || (v >= 21'h360 && v <= 21'h37F))) begin
                reject();
                return;
            end
            cp_acc = v;
            cont_left--;
            if (cont_left == 0) take_cp(cp_acc);
        endfunction

        // Accepted input beat
        function void note_byte(bit [7:0] b, bit is_last);
            span_result_t r;
            if (!outcome_fixed) begin
                if (byte_pos >= SPAN_LIMIT) begin
                    ovf_seen = 1'b1;
                    span_end();
                end
                else begin
                    take_byte(b);
                    if (!outcome_fixed && is_last) span_end();
                end
            end
            if (is_last) begin
                r.len = taken_len;
                r.re  = re_sum;
                r.im  = im_sum;
                r.ovf = ovf_seen;
                expected_q.push_back(r);
                spans++;
                if (r.len == 0) rejected++;
                if (r.ovf) ovf_spans++;
                if (r.im != 0) imag_spans++;
                clear_span();
            end
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10) $display("ERROR at %0t: result %0d: %s", $time, results, what);
        endfunction

        // Accepted output beat
        function void check_result(logic [LEN_W-1:0] len, logic signed [31:0] re,
                                   logic signed [31:0] im, logic ovf);
            span_result_t want;
            results++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result, length %0d", len));
                return;
            end
            want = expected_q.pop_front();
            if (len !== want.len)
                report($sformatf("length expected %0d, got %0d", want.len, len));
            if (re !== want.re)
                report($sformatf("real_part expected %0d, got %0d", want.re, re));
            if (im !== want.im)
                report($sformatf("imag_part expected %0d, got %0d", want.im, im));
            if (ovf !== want.ovf)
                report($sformatf("overflow expected %0b, got %0b", want.ovf, ovf));
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         byte_req  = 8'h00;
    logic               last      = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [LEN_W-1:0]   length;
    logic signed [31:0] real_part;
    logic signed [31:0] imag_part;
    logic               overflow;

    exponent_scoreboard sb = new();
    bit [7:0]           span_bytes[$];
    bit                 tx_idle = 1'b1;
    bit                 rx_idle = 1'b1;
    int unsigned        tx_count = 0;
    int unsigned        stall_left = 0;
    int unsigned        quiet_cycles = 0;

    superscript_complex_exponent_parser_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .byte_req  (byte_req),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .length    (length),
        .real_part (real_part),
        .imag_part (imag_part),
        .overflow  (overflow)
    );

    always #1 clk = ~clk;

    // Idle length: mostly short, now and then long
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (!rx_idle) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left == 0) begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_left = idle_len();
        end
        else stall_left--;
    end

    // Result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(length, real_part, imag_part, overflow);
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.expected_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ---------------- span building ----------------

    function automatic void put_raw(bit [7:0] b);
        span_bytes.push_back(b);
    endfunction

    function automatic void put_cp(bit [20:0] c);
        if (c < 21'h80) span_bytes.push_back(c[7:0]);
        else if (c < 21'h800) begin
            span_bytes.push_back({3'b110, c[10:6]});
            span_bytes.push_back({2'b10, c[5:0]});
        end
        else if (c < 21'h10000) begin
            span_bytes.push_back({4'b1110, c[15:12]});
            span_bytes.push_back({2'b10, c[11:6]});
            span_bytes.push_back({2'b10, c[5:0]});
        end
        else begin
            span_bytes.push_back({5'b11110, c[20:18]});
            span_bytes.push_back({2'b10, c[17:12]});
            span_bytes.push_back({2'b10, c[11:6]});
            span_bytes.push_back({2'b10, c[5:0]});
        end
    endfunction

    function automatic bit [20:0] sup_digit(int d);
        case (d)
            0:       return CP_SUP0;
            1:       return CP_SUP1;
            2:       return CP_SUP2;
            3:       return CP_SUP3;
            default: return CP_SUP4 + 21'(d - 4);
        endcase
    endfunction

    function automatic void put_number(bit [31:0] v);
        bit [3:0] ds[$];
        do begin
            ds.push_front(4'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (ds[k]) put_cp(sup_digit(ds[k]));
    endfunction

    function automatic void put_digit_run();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60)      n = 1;
        else if (r < 85) n = $urandom_range(2, 5);
        else if (r < 95) n = $urandom_range(9, 10);
        else             n = $urandom_range(11, 12);
        repeat (n) put_cp(sup_digit($urandom_range(0, 9)));
    endfunction

    function automatic bit [20:0] other_cp();
        case ($urandom_range(0, 4))
            0:       return 21'($urandom_range(0, 21'h7F));
            1:       return 21'($urandom_range(21'h2070, 21'h207F));
            2:       return 21'($urandom_range(21'h80, 21'h7FF));
            3:       return 21'($urandom_range(21'h800, 21'hFFFF));
            default: return 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
    endfunction

    // One term; a later term now and then loses its sign
    function automatic void put_term(bit later);
        int r;
        r = $urandom_range(0, 99);
        if (later ? (r >= 4) : (r < 40))
            put_cp($urandom_range(0, 1) ? CP_MINUS : CP_PLUS);
        case ($urandom_range(0, 3))
            0: put_digit_run();
            1:
            begin
                put_cp(CP_I);
                if ($urandom_range(0, 1)) put_digit_run();
            end
            2:
            begin
                put_digit_run();
                put_cp(CP_I);
            end
            default: put_cp(CP_I);
        endcase
        if ($urandom_range(0, 99) < 3) put_cp(CP_I);
    endfunction

    function automatic void build_wellformed();
        int n;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) put_term(k > 0);
        case ($urandom_range(0, 9))
            4, 5, 6: put_cp(other_cp());
            7, 8:    repeat ($urandom_range(2, 4)) put_cp(other_cp());
            9:       repeat ($urandom_range(1, 3)) put_raw(8'($urandom_range(0, 255)));
            default: ;
        endcase
    endfunction

    // Malformed UTF-8 inserted at position p
    function automatic void insert_bad(int p);
        bit [7:0] bad[$];
        case ($urandom_range(0, 7))
            0:       bad = '{8'hFF};
            1:       bad = '{8'hC0, 8'h80};
            2:       bad = '{8'hE0, 8'h80, 8'h80};
            3:       bad = '{8'hED, 8'hA0, 8'h80};
            4:       bad = '{8'hF4, 8'h90, 8'h80, 8'h80};
            5:       bad = '{8'hF8};
            6:       bad = '{8'h80};
            default: bad = '{8'hE2};
        endcase
        foreach (bad[k]) span_bytes.insert(p + k, bad[k]);
    endfunction

    function automatic void mutate();
        int n;
        int idx;
        n = span_bytes.size();
        idx = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: span_bytes[idx] = 8'($urandom_range(0, 255));
            1: if (n > 1) span_bytes.delete(idx);
            2: insert_bad(idx);
            3: if (n > 1) void'(span_bytes.pop_back());
            4: put_cp($urandom_range(0, 1) ? CP_MINUS : CP_PLUS);
            default: insert_bad(n);
        endcase
    endfunction

    // ---------------- driving ----------------

    task automatic send_byte(bit [7:0] b, bit is_last);
        int unsigned gap;
        gap = (tx_idle && $urandom_range(0, 1)) ? idle_len() : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        byte_req <= b;
        last     <= is_last;
        do @(posedge clk); while (in_stall);
        sb.note_byte(b, is_last);
        tx_count++;
    endtask

    task automatic send_span();
        int n;
        n = span_bytes.size();
        for (int k = 0; k < n; k++) send_byte(span_bytes[k], k == n - 1);
        span_bytes.delete();
    endtask

    // Hand-picked spans: every digit, i forms, signs, failures, wrap cases
    task automatic run_directed();
        for (int d = 0; d < 10; d++) put_cp(sup_digit(d));
        send_span();
        put_cp(CP_I);
        send_span();
        put_cp(CP_MINUS); put_cp(CP_I);
        send_span();
        put_cp(CP_SUP2); put_cp(CP_I);
        send_span();
        put_cp(CP_I); put_cp(CP_SUP3);
        send_span();
        // mixed terms, then plain text ends the parse and later terms are ignored
        put_cp(CP_PLUS); put_number(5); put_cp(CP_MINUS); put_number(3); put_cp(CP_I);
        put_cp(CP_PLUS); put_cp(CP_I); put_number(7); put_raw(8'h78);
        put_cp(CP_PLUS); put_number(1);
        send_span();
        // sign with nothing after it
        put_cp(CP_PLUS);
        send_span();
        // later term without a sign
        put_cp(CP_SUP2); put_cp(CP_I); put_cp(CP_SUP3);
        send_span();
        // doubled i, and i on both sides of a number
        put_cp(CP_I); put_cp(CP_I);
        send_span();
        put_cp(CP_I); put_cp(CP_SUP2); put_cp(CP_I);
        send_span();
        // malformed UTF-8
        put_cp(CP_SUP1); put_raw(8'hFF);
        send_span();
        put_cp(CP_SUP1); put_raw(8'hC2); put_raw(8'h41);
        send_span();
        put_raw(8'hE0); put_raw(8'h80); put_raw(8'h80);
        send_span();
        put_raw(8'hED); put_raw(8'hA0); put_raw(8'h80);
        send_span();
        put_raw(8'hF4); put_raw(8'h90); put_raw(8'h80); put_raw(8'h80);
        send_span();
        // code point cut off by the end of the span
        put_cp(CP_SUP4); put_raw(8'hE2); put_raw(8'h81);
        send_span();
        // number and sum wrap
        put_number(32'h8000_0000);
        send_span();
        put_number(32'h7FFF_FFFF); put_cp(CP_PLUS); put_number(1);
        send_span();
        put_cp(CP_MINUS); put_number(32'h8000_0000);
        send_span();
        put_cp(CP_MINUS); put_number(32'h7FFF_FFFF); put_cp(CP_MINUS); put_number(2);
        send_span();
        // no term at all
        put_raw(8'h00);
        send_span();
        put_raw(8'h7F);
        send_span();
        put_cp(21'h10FFFF);
        send_span();
    endtask

    initial
    begin
        int unsigned rand_bytes;
        int unsigned span_cnt;
        int unsigned mark;
        int r;
        rand_bytes = 0;
        span_cnt   = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // Random spans, mostly well formed with random content
        while (rand_bytes < 1800) begin
            if (span_cnt % 25 == 0) begin
                r = $urandom_range(0, 3);
                tx_idle = r[0];
                rx_idle = r[1];
            end
            r = $urandom_range(0, 99);
            if (r < 8) repeat ($urandom_range(1, 8)) put_raw(8'($urandom_range(0, 255)));
            else begin
                build_wellformed();
                if (r >= 70) mutate();
            end
            mark = tx_count;
            send_span();
            rand_bytes += tx_count - mark;
            span_cnt++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d bytes in %0d spans: %0d exponents parsed, %0d rejected,",
                 tx_count, sb.spans, sb.spans - sb.rejected, sb.rejected);
        $display("%0d results flagged overflow, %0d had an imaginary part; %0d mismatches.",
                 sb.ovf_spans, sb.imag_spans, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
